### hw/rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define HRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/hrf_pkg.sv
// Types, constants and character helpers for the HTTP request framer.
`default_nettype none

package hrf_pkg;

  localparam int unsigned LenW = 31;
  localparam logic [LenW-1:0] MaxBodyReset = 31'd1048576;

  localparam logic [3:0] KeywordLen = 4'd15;
  localparam logic [1:0] TermLast   = 2'd3;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Progress through the Content-Length value
  typedef enum logic [3:0] {
    VpNone   = 4'b0001,  // keyword not seen yet
    VpSkip   = 4'b0010,  // skipping blanks after the keyword
    VpDigits = 4'b0100,  // reading digits
    VpDone   = 4'b1000   // value finished
  } value_phase_e;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_body;
    logic       message_end;
    logic       length_error;
  } hrf_result_t;

  // Character at a position of "Content-Length:"
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Character at a position of CR LF CR LF
  function automatic logic [7:0] term_char(input logic [1:0] idx);
    return idx[0] ? CharLf : CharCr;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/hrf_rx_if.sv
// Input byte channel of the framer.
`default_nettype none

interface hrf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/hrf_tx_if.sv
// Result channel of the framer: byte plus framing flags.
`default_nettype none

interface hrf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       in_body;
  logic       message_end;
  logic       length_error;

  modport source (output valid, output out_byte, output in_body, output message_end,
                  output length_error, input ready);
  modport sink (input valid, input out_byte, input in_body, input message_end,
                input length_error, output ready);
endinterface

`default_nettype wire

### hw/rtl/hrf_parser.sv
// Per-byte framing state: terminator and keyword match, length parse, body count.
`default_nettype none

`include "assert_macros.svh"

module hrf_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic [hrf_pkg::LenW-1:0]    max_body_bytes_i,
  output hrf_pkg::hrf_result_t             res_o
);
  import hrf_pkg::*;

  logic             phase_body_q, phase_body_d;
  logic [1:0]       term_match_q, term_match_d;
  logic [3:0]       kw_match_q, kw_match_d;
  value_phase_e     value_phase_q, value_phase_d;
  logic [LenW-1:0]  decl_len_q, decl_len_d;
  logic [LenW-1:0]  body_left_q, body_left_d;
  logic             error_seen_q, error_seen_d;

  logic             is_digit, is_blank;
  logic [LenW+3:0]  acc_wide;
  logic             acc_sat;
  logic [LenW-1:0]  acc_len;
  logic [LenW-1:0]  body_dec;
  logic [3:0]       kw_next;
  logic             hdr_done;
  logic             clear_msg;

  // Byte class and decimal accumulate with saturation
  always_comb begin
    is_digit = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
    is_blank = (rx_byte_i == CharSpace) || (rx_byte_i == CharTab);
    acc_wide = ({4'b0, decl_len_q} << 3) + ({4'b0, decl_len_q} << 1)
             + {{LenW{1'b0}}, rx_byte_i[3:0]};
    acc_sat  = acc_wide > {4'b0, max_body_bytes_i};
    acc_len  = acc_sat ? max_body_bytes_i : acc_wide[LenW-1:0];
    body_dec = (body_left_q != '0) ? body_left_q - 1'b1 : body_left_q;
  end

  // Next state and result for the byte at the input
  always_comb begin
    phase_body_d  = phase_body_q;
    term_match_d  = term_match_q;
    kw_match_d    = kw_match_q;
    value_phase_d = value_phase_q;
    decl_len_d    = decl_len_q;
    body_left_d   = body_left_q;
    error_seen_d  = error_seen_q;
    kw_next       = '0;
    hdr_done      = 1'b0;
    clear_msg     = 1'b0;

    res_o.out_byte     = rx_byte_i;
    res_o.in_body      = phase_body_q;
    res_o.message_end  = 1'b0;
    res_o.length_error = 1'b0;

    if (phase_body_q) begin
      body_left_d = body_dec;
      if (body_dec == '0) begin
        res_o.message_end  = 1'b1;
        res_o.length_error = error_seen_q;
        clear_msg          = 1'b1;
      end
    end else begin
      // length value
      case (value_phase_q)
        VpSkip: begin
          if (!is_blank) begin
            if (!is_digit) begin
              decl_len_d    = '0;
              error_seen_d  = 1'b1;
              value_phase_d = VpDone;
            end else begin
              value_phase_d = VpDigits;
              decl_len_d    = acc_len;
              if (acc_sat) error_seen_d = 1'b1;
            end
          end
        end
        VpDigits: begin
          if (!is_digit) begin
            value_phase_d = VpDone;
          end else begin
            decl_len_d = acc_len;
            if (acc_sat) error_seen_d = 1'b1;
          end
        end
        default: ;
      endcase

      // keyword, first occurrence only
      if (value_phase_q == VpNone) begin
        if ((kw_match_q < KeywordLen) && (rx_byte_i == kw_char(kw_match_q))) begin
          kw_next = kw_match_q + 4'd1;
        end else begin
          kw_next = (rx_byte_i == kw_char(4'd0)) ? 4'd1 : 4'd0;
        end
        if (kw_next >= KeywordLen) begin
          kw_match_d    = '0;
          value_phase_d = VpSkip;
          decl_len_d    = '0;
        end else begin
          kw_match_d = kw_next;
        end
      end

      // blank-line terminator
      if (rx_byte_i == term_char(term_match_q)) begin
        if (term_match_q == TermLast) begin
          hdr_done = 1'b1;
        end else begin
          term_match_d = term_match_q + 2'd1;
        end
      end else begin
        term_match_d = (rx_byte_i == CharCr) ? 2'd1 : 2'd0;
      end

      if (hdr_done) begin
        term_match_d = '0;
        if (value_phase_d == VpSkip) begin
          decl_len_d   = '0;
          error_seen_d = 1'b1;
        end
        if (value_phase_d != VpNone) value_phase_d = VpDone;
        body_left_d = decl_len_d;
        if (decl_len_d == '0) begin
          res_o.message_end  = 1'b1;
          res_o.length_error = error_seen_d;
          clear_msg          = 1'b1;
        end else begin
          phase_body_d = 1'b1;
        end
      end
    end

    // message end: back to a fresh header
    if (clear_msg) begin
      phase_body_d  = 1'b0;
      term_match_d  = '0;
      kw_match_d    = '0;
      value_phase_d = VpNone;
      decl_len_d    = '0;
      body_left_d   = '0;
      error_seen_d  = 1'b0;
    end
  end

  // State registers, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_body_q  <= 1'b0;
      term_match_q  <= '0;
      kw_match_q    <= '0;
      value_phase_q <= VpNone;
      decl_len_q    <= '0;
      body_left_q   <= '0;
      error_seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_body_q  <= phase_body_d;
      term_match_q  <= term_match_d;
      kw_match_q    <= kw_match_d;
      value_phase_q <= value_phase_d;
      decl_len_q    <= decl_len_d;
      body_left_q   <= body_left_d;
      error_seen_q  <= error_seen_d;
    end
  end

  `HRF_ASSERT_ALWAYS(a_body_nonzero, phase_body_q |-> body_left_q != '0, "body phase with nothing left")
  `HRF_ASSERT(a_end_clears, step_i && res_o.message_end |=> !phase_body_q && value_phase_q == VpNone && term_match_q == '0, "state not cleared after message end")
  `HRF_ASSERT_ALWAYS(a_no_len_without_kw, value_phase_q == VpNone |-> decl_len_q == '0, "length built before keyword")

endmodule

`default_nettype wire

### hw/rtl/http_request_framer.sv
// HTTP request framer top level: handshakes, limit register, result register.
// Takes one request byte per cycle unless the output stalls, and returns it from the result
// register in the following cycle with header/body and message-end flags; a length
// error is flagged on the message-end word. The sustained rate is one byte per clock:
// all matching and the decimal length update for a byte are combinational between the
// framing state registers and the result register, and a new byte is taken whenever
// the result register is empty or being drained. max_body_bytes resets to 1048576 and
// is written through cfg_we_i/cfg_wdata_i; a write takes effect on the next byte.
`default_nettype none

`include "assert_macros.svh"

module http_request_framer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [hrf_pkg::LenW-1:0]  cfg_wdata_i,
  hrf_rx_if.sink                         rx_i,
  hrf_tx_if.source                       tx_o
);
  import hrf_pkg::*;

  logic [LenW-1:0] max_body_q;
  logic            out_valid_q, out_valid_d;
  hrf_result_t     out_res_q;
  hrf_result_t     step_res;
  logic            step;

  // Length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyReset;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  // Accept while the result register is free or being taken
  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign step       = rx_i.valid && rx_i.ready;

  hrf_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .rx_byte_i        (rx_i.rx_byte),
    .max_body_bytes_i (max_body_q),
    .res_o            (step_res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= step_res;
    end
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.out_byte     = out_res_q.out_byte;
  assign tx_o.in_body      = out_res_q.in_body;
  assign tx_o.message_end  = out_res_q.message_end;
  assign tx_o.length_error = out_res_q.length_error;

  `HRF_ASSERT(a_accept_fills, rx_i.valid && rx_i.ready |=> tx_o.valid, "accepted word not presented")
  `HRF_ASSERT(a_err_on_end, tx_o.valid && tx_o.length_error |-> tx_o.message_end, "length error off message end")
  `HRF_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> rx_i.ready, "stalled with empty result register")

endmodule

`default_nettype wire
